// ===== rtl/core/lpm_pkg.sv =====
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared types, constants and helpers for the multichannel ladder low-pass.
// ----------------------------------------------------------------------------
package lpm_pkg;

    localparam int NUM_CHANNELS      = 16;
    localparam int OVERSAMPLE_PASSES = 2;

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PASS_W = (OVERSAMPLE_PASSES > 1) ? $clog2(OVERSAMPLE_PASSES) : 1;

    // Field widths
    localparam int SMP_W = 24;
    localparam int CUT_W = 18;
    localparam int RES_W = 15;
    localparam int CHN_W = 4;

    // Shared multiplier operand widths: wide data side, signed weight side
    localparam int OPA_W = 28;
    localparam int OPW_W = 18;

    localparam int Q20_ONE = 1048576;
    localparam int S24_MAX = 8388607;
    localparam int S24_MIN = -8388608;
    localparam int CUT_ONE = 65536;

    // Q16 smoothing weights, each pair sums to one
    localparam logic signed [OPW_W-1:0] W_FB_OLD = 18'sd27394;
    localparam logic signed [OPW_W-1:0] W_FB_NEW = 18'sd38142;
    localparam logic signed [OPW_W-1:0] W_PH_NEW = 18'sd23593;
    localparam logic signed [OPW_W-1:0] W_PH_OLD = 18'sd41943;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_WRITE,
        ST_STORE
    } t_state;

    typedef enum logic [2:0] {
        OP_DRIVE,
        OP_FEEDBACK,
        OP_PHASE,
        OP_POLE1,
        OP_POLE2,
        OP_POLE3,
        OP_POLE4
    } t_op;

    typedef enum logic [1:0] {
        LIM_NONE,
        LIM_S24,
        LIM_UNIT
    } t_lim;

    typedef struct packed {
        t_op  op;
        logic mul_b;
        logic wr;
        logic store;
        logic ready;
    } t_seq_ctl;

    typedef struct packed {
        logic load_acc;
        logic short_round;
        t_lim lim;
    } t_mac_ctl;

    // Fold the channel field onto the instances that exist
    function automatic logic [CH_W-1:0] chan_index(input logic [CHN_W-1:0] c);
        logic [CH_W-1:0] idx;
        idx = '0;
        for (int k = 0; k < (1 << CHN_W); k++) begin
            if (c == CHN_W'(k)) begin
                idx = CH_W'(k % NUM_CHANNELS);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/core/ladder_lowpass_multichannel.sv =====
// ----------------------------------------------------------------------------
// ladder_lowpass_multichannel
// Four-pole resonant ladder low-pass with per-channel state and two
// oversampled passes per sample, run on one shared multiply-accumulate.
// ----------------------------------------------------------------------------
//  channel   dir  bits  fields (low bit up)
//  s_axis    in   64    sample_in[23:0] cutoff[41:24] resonance[56:42]
//                       channel[60:57], zero pad [63:61]
//  m_axis    out  24    sample_out[23:0]
//
//  One item runs seven operations per pass, each through the states MUL_A,
//  MUL_B and WRITE on the shared MAC (two products, then sum, round and
//  limit), between the accept and store cycles.
//  s_axis_tready is high only while idle. A result waiting in the output
//  register does not block the next accept; the store waits for it.
//  Synchronous active-low reset clears all channel state and the output valid flag.
// ----------------------------------------------------------------------------
module ladder_lowpass_multichannel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // sample_in, cutoff, resonance, channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // sample_out
);

    localparam int OPA_W = lpm_pkg::OPA_W;
    localparam int OPW_W = lpm_pkg::OPW_W;
    localparam int NCH   = lpm_pkg::NUM_CHANNELS;

    lpm_pkg::t_seq_ctl seq;
    lpm_pkg::t_mac_ctl mac_ctl;

    logic in_fire;
    logic out_free;

    logic signed [23:0] in_sample;
    logic signed [17:0] in_cutoff;
    logic [14:0]        in_res;
    logic [lpm_pkg::CH_W-1:0] in_ch;
    logic [16:0]        in_f;

    // Per-channel state
    logic signed [23:0] r_fb_mem [NCH];
    logic signed [23:0] r_s1_mem [NCH];
    logic signed [23:0] r_s2_mem [NCH];
    logic signed [23:0] r_s3_mem [NCH];
    logic signed [23:0] r_s4_mem [NCH];

    // Working copy of the addressed channel
    logic signed [23:0] r_x;
    logic [16:0]        r_f;
    logic [16:0]        r_g;
    logic [14:0]        r_q;
    logic [lpm_pkg::CH_W-1:0] r_ch;
    logic signed [23:0] r_fb;
    logic signed [23:0] r_s1;
    logic signed [23:0] r_s2;
    logic signed [23:0] r_s3;
    logic signed [23:0] r_s4;
    logic signed [23:0] r_prev;
    logic signed [OPA_W-1:0] r_drive;
    logic signed [24:0] r_u;

    logic               r_out_valid;
    logic [23:0]        r_out_data;

    logic signed [OPA_W-1:0] a_data, b_data, opa;
    logic signed [OPW_W-1:0] a_w, b_w, opw, w_f, w_g;
    logic signed [OPA_W-1:0] mac_res;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    assign in_sample = $signed(s_axis_tdata[23:0]);
    assign in_cutoff = $signed(s_axis_tdata[41:24]);
    assign in_res    = s_axis_tdata[56:42];
    assign in_ch     = lpm_pkg::chan_index(s_axis_tdata[60:57]);

    // Clamp cutoff to 0..1.0
    always_comb begin
        if (in_cutoff < 18'sd0) begin
            in_f = '0;
        end else if (in_cutoff > 18'sd65536) begin
            in_f = 17'(lpm_pkg::CUT_ONE);
        end else begin
            in_f = in_cutoff[16:0];
        end
    end

    lpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_free (out_free),
        .o_ctl      (seq)
    );

    assign w_f = $signed({1'b0, r_f});
    assign w_g = $signed({1'b0, r_g});

    // Operand select per operation
    always_comb begin
        unique case (seq.op)
            lpm_pkg::OP_DRIVE: begin
                a_data = OPA_W'(r_s4);    a_w = $signed({3'b000, r_q});
                b_data = '0;              b_w = '0;
            end
            lpm_pkg::OP_FEEDBACK: begin
                a_data = OPA_W'(r_fb);    a_w = lpm_pkg::W_FB_OLD;
                b_data = r_drive;         b_w = lpm_pkg::W_FB_NEW;
            end
            lpm_pkg::OP_PHASE: begin
                a_data = OPA_W'(r_fb);    a_w = lpm_pkg::W_PH_NEW;
                b_data = OPA_W'(r_prev);  b_w = lpm_pkg::W_PH_OLD;
            end
            lpm_pkg::OP_POLE1: begin
                a_data = OPA_W'(r_u);     a_w = w_f;
                b_data = OPA_W'(r_s1);    b_w = w_g;
            end
            lpm_pkg::OP_POLE2: begin
                a_data = OPA_W'(r_s1);    a_w = w_f;
                b_data = OPA_W'(r_s2);    b_w = w_g;
            end
            lpm_pkg::OP_POLE3: begin
                a_data = OPA_W'(r_s2);    a_w = w_f;
                b_data = OPA_W'(r_s3);    b_w = w_g;
            end
            default: begin
                a_data = OPA_W'(r_s3);    a_w = w_f;
                b_data = OPA_W'(r_s4);    b_w = w_g;
            end
        endcase
        opa = seq.mul_b ? b_data : a_data;
        opw = seq.mul_b ? b_w : a_w;

        mac_ctl.load_acc    = seq.mul_b;
        mac_ctl.short_round = (seq.op == lpm_pkg::OP_DRIVE);
        unique case (seq.op)
            lpm_pkg::OP_DRIVE, lpm_pkg::OP_PHASE: mac_ctl.lim = lpm_pkg::LIM_NONE;
            lpm_pkg::OP_POLE1:                    mac_ctl.lim = lpm_pkg::LIM_UNIT;
            default:                              mac_ctl.lim = lpm_pkg::LIM_S24;
        endcase
    end

    lpm_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_opa    (opa),
        .i_opw    (opw),
        .o_result (mac_res)
    );

    // Working registers: load on transfer, update on each write step
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x  <= in_sample;
            r_f  <= in_f;
            r_g  <= 17'(lpm_pkg::CUT_ONE) - in_f;
            r_q  <= in_res;
            r_ch <= in_ch;
            r_fb <= r_fb_mem[in_ch];
            r_s1 <= r_s1_mem[in_ch];
            r_s2 <= r_s2_mem[in_ch];
            r_s3 <= r_s3_mem[in_ch];
            r_s4 <= r_s4_mem[in_ch];
        end else if (seq.wr) begin
            unique case (seq.op)
                lpm_pkg::OP_DRIVE: begin
                    r_drive <= mac_res;
                    // Limit only the upper side of the previous feedback
                    r_prev  <= (r_fb > 24'(lpm_pkg::Q20_ONE)) ?
                               24'(lpm_pkg::Q20_ONE) : r_fb;
                end
                lpm_pkg::OP_FEEDBACK: r_fb <= mac_res[23:0];
                lpm_pkg::OP_PHASE:    r_u  <= 25'(r_x) - mac_res[24:0];
                lpm_pkg::OP_POLE1:    r_s1 <= mac_res[23:0];
                lpm_pkg::OP_POLE2:    r_s2 <= mac_res[23:0];
                lpm_pkg::OP_POLE3:    r_s3 <= mac_res[23:0];
                default:              r_s4 <= mac_res[23:0];
            endcase
        end
    end

    // Channel state: cleared at reset, written back after the last pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCH; i++) begin
                r_fb_mem[i] <= '0;
                r_s1_mem[i] <= '0;
                r_s2_mem[i] <= '0;
                r_s3_mem[i] <= '0;
                r_s4_mem[i] <= '0;
            end
        end else if (seq.store) begin
            r_fb_mem[r_ch] <= r_fb;
            r_s1_mem[r_ch] <= r_s1;
            r_s2_mem[r_ch] <= r_s2;
            r_s3_mem[r_ch] <= r_s3;
            r_s4_mem[r_ch] <= r_s4;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq.store) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq.store) begin
            r_out_data <= r_s4;
        end
    end

    assign s_axis_tready = seq.ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/core/lpm_mac.sv =====
// ----------------------------------------------------------------------------
// lpm_mac
// Shared two-term multiply-accumulate with rounding shift and limiting.
// ----------------------------------------------------------------------------
module lpm_mac (
    input  logic                                 i_clk,
    input  lpm_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [lpm_pkg::OPA_W-1:0]     i_opa,
    input  logic signed [lpm_pkg::OPW_W-1:0]     i_opw,
    output logic signed [lpm_pkg::OPA_W-1:0]     o_result
);

    localparam int PROD_W = lpm_pkg::OPA_W + lpm_pkg::OPW_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic signed [SUM_W-1:0] HI_S24  = SUM_W'(lpm_pkg::S24_MAX);
    localparam logic signed [SUM_W-1:0] LO_S24  = SUM_W'(lpm_pkg::S24_MIN);
    localparam logic signed [SUM_W-1:0] HI_UNIT = SUM_W'(lpm_pkg::Q20_ONE);
    localparam logic signed [SUM_W-1:0] LO_UNIT = -SUM_W'(lpm_pkg::Q20_ONE);
    localparam logic signed [SUM_W-1:0] HALF_12 = SUM_W'(1 << 11);
    localparam logic signed [SUM_W-1:0] HALF_16 = SUM_W'(1 << 15);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  rnd;
    logic signed [SUM_W-1:0]  shifted;
    logic signed [SUM_W-1:0]  limited;

    always_ff @(posedge i_clk) begin
        r_prod <= i_opa * i_opw;
        if (i_ctl.load_acc) begin
            r_acc <= r_prod;
        end
    end

    always_comb begin
        sum     = SUM_W'(r_acc) + SUM_W'(r_prod);
        rnd     = sum + (i_ctl.short_round ? HALF_12 : HALF_16);
        shifted = i_ctl.short_round ? (rnd >>> 12) : (rnd >>> 16);
        unique case (i_ctl.lim)
            lpm_pkg::LIM_S24: begin
                if (shifted > HI_S24) limited = HI_S24;
                else if (shifted < LO_S24) limited = LO_S24;
                else limited = shifted;
            end
            lpm_pkg::LIM_UNIT: begin
                if (shifted > HI_UNIT) limited = HI_UNIT;
                else if (shifted < LO_UNIT) limited = LO_UNIT;
                else limited = shifted;
            end
            default: begin
                limited = shifted;
            end
        endcase
        o_result = lpm_pkg::OPA_W'(limited);
    end

endmodule

// ===== rtl/core/lpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpm_ctrl
// Sequencer: walks the seven operations of each pass through the shared MAC.
// ----------------------------------------------------------------------------
module lpm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_fire,
    input  logic              i_out_free,
    output lpm_pkg::t_seq_ctl o_ctl
);

    lpm_pkg::t_state r_state, n_state;
    lpm_pkg::t_op    r_op, n_op;
    logic [lpm_pkg::PASS_W-1:0] r_pass, n_pass;
    logic last_step;

    assign last_step = (r_op == lpm_pkg::OP_POLE4) &&
                       (r_pass == lpm_pkg::PASS_W'(lpm_pkg::OVERSAMPLE_PASSES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpm_pkg::ST_IDLE;
            r_op    <= lpm_pkg::OP_DRIVE;
            r_pass  <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_pass  <= n_pass;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpm_pkg::ST_IDLE:  if (i_in_fire) n_state = lpm_pkg::ST_MUL_A;
            lpm_pkg::ST_MUL_A: n_state = lpm_pkg::ST_MUL_B;
            lpm_pkg::ST_MUL_B: n_state = lpm_pkg::ST_WRITE;
            lpm_pkg::ST_WRITE: n_state = last_step ? lpm_pkg::ST_STORE : lpm_pkg::ST_MUL_A;
            lpm_pkg::ST_STORE: if (i_out_free) n_state = lpm_pkg::ST_IDLE;
            default:           n_state = lpm_pkg::ST_IDLE;
        endcase
    end

    // Operation and pass counters
    always_comb begin
        n_op   = r_op;
        n_pass = r_pass;
        if (i_in_fire) begin
            n_op   = lpm_pkg::OP_DRIVE;
            n_pass = '0;
        end else if (r_state == lpm_pkg::ST_WRITE) begin
            if (r_op == lpm_pkg::OP_POLE4) begin
                n_op   = lpm_pkg::OP_DRIVE;
                n_pass = r_pass + 1'b1;
            end else begin
                n_op = lpm_pkg::t_op'(r_op + 3'd1);
            end
        end
    end

    // Outputs
    always_comb begin
        o_ctl.op    = r_op;
        o_ctl.mul_b = (r_state == lpm_pkg::ST_MUL_B);
        o_ctl.wr    = (r_state == lpm_pkg::ST_WRITE);
        o_ctl.store = (r_state == lpm_pkg::ST_STORE) && i_out_free;
        o_ctl.ready = (r_state == lpm_pkg::ST_IDLE);
    end

endmodule

// ===== test/ladder_lowpass_check.sv =====
// ----------------------------------------------------------------------------
// ladder_lowpass_check
// Watches both stream channels of the ladder low-pass, predicts each filtered
// sample from its own per-channel filter state and compares in order.
// ----------------------------------------------------------------------------
module ladder_lowpass_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_data,    // sample_in, cutoff, resonance, channel
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,   // sample_out
    output int          o_mismatches,
    output int          o_pending,
    output int          o_results
);

    longint fb_level [lpm_pkg::NUM_CHANNELS];
    longint pole1    [lpm_pkg::NUM_CHANNELS];
    longint pole2    [lpm_pkg::NUM_CHANNELS];
    longint pole3    [lpm_pkg::NUM_CHANNELS];
    longint pole4    [lpm_pkg::NUM_CHANNELS];

    logic [23:0] filtered_q [$];
    logic [23:0] want;
    int          miss_n = 0;
    int          seen_n = 0;

    // Round half up, then floor shift
    function automatic longint round_q(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic longint wsum(input longint a, input longint wa,
                                    input longint b, input longint wb);
        return clip(round_q(a * wa + b * wb, 16), lpm_pkg::S24_MIN, lpm_pkg::S24_MAX);
    endfunction

    function automatic logic [23:0] ladder_step(input logic [63:0] d);
        longint x, f, g, q, prev, drive, ph, u;
        int     ch;
        x  = $signed(d[23:0]);
        f  = $signed(d[41:24]);
        q  = d[56:42];
        ch = int'(d[60:57]) % lpm_pkg::NUM_CHANNELS;
        f  = clip(f, 0, lpm_pkg::CUT_ONE);
        g  = lpm_pkg::CUT_ONE - f;
        for (int p = 0; p < lpm_pkg::OVERSAMPLE_PASSES; p++) begin
            // only the upper bound limits the previous feedback
            prev = (fb_level[ch] > lpm_pkg::Q20_ONE) ? longint'(lpm_pkg::Q20_ONE)
                                                     : fb_level[ch];
            drive = round_q(q * pole4[ch], 12);
            fb_level[ch] = wsum(fb_level[ch], lpm_pkg::W_FB_OLD, drive, lpm_pkg::W_FB_NEW);
            ph = round_q(fb_level[ch] * lpm_pkg::W_PH_NEW + prev * lpm_pkg::W_PH_OLD, 16);
            u  = x - ph;
            pole1[ch] = clip(round_q(u * f + pole1[ch] * g, 16),
                             -lpm_pkg::Q20_ONE, lpm_pkg::Q20_ONE);
            pole2[ch] = wsum(pole1[ch], f, pole2[ch], g);
            pole3[ch] = wsum(pole2[ch], f, pole3[ch], g);
            pole4[ch] = wsum(pole3[ch], f, pole4[ch], g);
        end
        return pole4[ch][23:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < lpm_pkg::NUM_CHANNELS; c++) begin
                fb_level[c] = 0;
                pole1[c]    = 0;
                pole2[c]    = 0;
                pole3[c]    = 0;
                pole4[c]    = 0;
            end
            filtered_q.delete();
        end else begin
            // check the output first: a result never comes from this edge's input
            if (i_out_valid && i_out_ready) begin
                seen_n++;
                if (filtered_q.size() == 0) begin
                    if (miss_n < 10) begin
                        $display("output %0d unexpected: got %h, nothing pending",
                                 seen_n, i_out_data);
                    end
                    miss_n++;
                end else begin
                    want = filtered_q.pop_front();
                    if (want !== i_out_data) begin
                        if (miss_n < 10) begin
                            $display("output %0d sample_out differs: expected %h, got %h",
                                     seen_n, want, i_out_data);
                        end
                        miss_n++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                filtered_q.push_back(ladder_step(i_in_data));
            end
        end
        o_mismatches <= miss_n;
        o_pending    <= filtered_q.size();
        o_results    <= seen_n;
    end

endmodule

// ===== test/ladder_lowpass_multichannel_test.sv =====
// ----------------------------------------------------------------------------
// ladder_lowpass_multichannel_test
// Drives the ladder low-pass with directed edge samples and then with runs of
// steady cutoff and resonance per channel, mixed with noise, under random
// sender bursts and receiver stalls; a side checker predicts every result.
// ----------------------------------------------------------------------------
module ladder_lowpass_multichannel_test;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;   // sample_in, cutoff, resonance, channel
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // sample_out

    int mismatches;
    int pending;
    int results;
    int sent       = 0;
    int burst_left = 0;
    int rx_mode    = 0;
    int rx_span    = 0;
    int rx_tick    = 0;

    ladder_lowpass_multichannel uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ladder_lowpass_check checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: switch between always ready, coin flip, sparse and long stalls
    always @(posedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode = $urandom_range(3, 0);
            rx_span = $urandom_range(300, 40);
        end
        rx_span--;
        rx_tick++;
        case (rx_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom_range(1, 0));
            end
            2: begin
                m_axis_tready <= (rx_tick % 8 == 0);
            end
            default: begin
                m_axis_tready <= (rx_tick % 64 >= 50);
            end
        endcase
    end

    task automatic send_sample(input logic [23:0] smp, input logic [17:0] cut,
                               input logic [14:0] res, input logic [3:0] chn);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            if ($urandom_range(3, 0) != 0) begin
                gap = $urandom_range(60, 1);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, chn, res, cut, smp};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    // Hold off the sender until every pending result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [17:0] pick_cutoff();
        if ($urandom_range(7, 0) == 0) begin
            return 18'($urandom);
        end
        return 18'($urandom_range(lpm_pkg::CUT_ONE, 0));
    endfunction

    function automatic logic [14:0] pick_resonance();
        if ($urandom_range(7, 0) == 0) begin
            return 15'($urandom);
        end
        return 15'($urandom_range(24576, 0));
    endfunction

    initial begin
        logic [17:0] cut;
        logic [14:0] res;
        logic [3:0]  chn;
        int          amp;
        int          run;
        bit          paused;
        paused = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero, full-scale steps with pole one clipping, cutoff out
        // of range both ways, resonance at and above 6.0 until feedback saturates
        send_sample(24'h000000, 18'd0, 15'd0, 4'd0);
        send_sample(24'h7FFFFF, 18'd65536, 15'd0, 4'd0);
        send_sample(24'h800000, 18'd65536, 15'd0, 4'd0);
        send_sample(24'h7FFFFF, 18'h1FFFF, 15'd24576, 4'd1);
        repeat (5) send_sample(24'h7FFFFF, 18'h1FFFF, 15'h7FFF, 4'd1);
        send_sample(24'h800000, 18'h20000, 15'h7FFF, 4'd1);
        repeat (3) send_sample(24'h800000, 18'd65536, 15'h7FFF, 4'd1);
        send_sample(24'h100000, 18'd32768, 15'd4096, 4'd15);
        send_sample(24'hF00000, 18'd1, 15'd24576, 4'd15);
        send_sample(24'h000001, 18'd65535, 15'd1, 4'd15);
        send_sample(24'h7FFFFF, 18'd0, 15'd24576, 4'd2);
        repeat (4) send_sample(24'h7FFFFF, 18'd65536, 15'd24576, 4'd3);
        drain_results();

        // Random: steady runs per channel with square or noisy content
        while (sent < 420) begin
            chn = 4'($urandom);
            cut = pick_cutoff();
            res = pick_resonance();
            amp = ($urandom_range(3, 0) == 0) ? $urandom_range(1048576, 0)
                                              : $urandom_range(8388607, 0);
            run = $urandom_range(16, 4);
            for (int k = 0; k < run; k++) begin
                if ($urandom_range(4, 0) == 0) begin
                    send_sample(24'($urandom), pick_cutoff(), pick_resonance(),
                                4'($urandom));
                end
                if ($urandom_range(3, 0) == 0) begin
                    send_sample(24'($urandom), cut, res, chn);
                end else begin
                    send_sample((k % 4 < 2) ? 24'(amp) : 24'(-amp), cut, res, chn);
                end
            end
            if (!paused && sent > 220) begin
                drain_results();
                paused = 1'b1;
            end
        end

        drain_results();
        repeat (100) @(posedge i_clk);

        $display("Ran %0d samples across %0d channels, %0d filtered results checked",
                 sent, lpm_pkg::NUM_CHANNELS, results);
        $display("Directed clip, cutoff clamp and feedback saturation cases, then steady runs");
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
